### rtl/t1fb_pkg.sv
// Package for the T=1 block frame builder: opcodes, constants, item and state
// records, and the reflected CRC-16 byte step.
// No dependencies.
package t1fb_pkg;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_START_CTRL = 2'd0,
    OP_START_SEQ  = 2'd1,
    OP_DATA       = 2'd2,
    OP_UNUSED     = 2'd3
  } opcode_t;

  localparam logic [12:0] MAX_INFO_LEN = 13'd4088;
  localparam logic [7:0]  CTRL_RESYNC  = 8'hCF;
  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;

  // One accepted transaction, decoded into the bytes it emits
  typedef struct packed {
    logic            is_err;       // single error result
    logic            restart_crc;  // first byte restarts the CRC
    logic            add_crc;      // close with the two CRC bytes
    logic [2:0]      nbytes;       // header/data bytes to send (1 or 4; 0 on error)
    logic [3:0][7:0] bytes;
    logic [2:0]      nsteps;       // total results of this transaction
  } item_t;

  // Framing state carried from one transaction to the next
  typedef struct packed {
    logic        seq;
    logic        open;
    logic [12:0] rem;
  } frame_state_t;

  // CRC-16, reflected polynomial 0x8408, one byte per call
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/t1fb_decode.sv
// Transaction decoder: turns one input transaction and the framing state into
// the list of bytes to emit and the next framing state. Uses t1fb_pkg.
module t1fb_decode (
  input  logic [1:0]            opcode,
  input  logic [7:0]            control_byte,
  input  logic [12:0]           info_length,
  input  logic                  has_data,
  input  logic [7:0]            data_byte,
  input  logic [7:0]            node_address,
  input  t1fb_pkg::frame_state_t state_i,
  output logic                  item_valid,
  output t1fb_pkg::item_t       item_o,
  output t1fb_pkg::frame_state_t state_o
);

  logic [7:0]  ctrl;
  logic [12:0] rem_dec;

  always_comb begin
    item_valid         = 1'b1;
    item_o             = '0;
    state_o            = state_i;
    ctrl               = control_byte;
    rem_dec            = state_i.rem - 13'd1;

    unique case (t1fb_pkg::opcode_t'(opcode))
      t1fb_pkg::OP_UNUSED: begin
        item_valid = 1'b0;
      end
      t1fb_pkg::OP_DATA: begin
        if (!state_i.open || (state_i.rem == '0)) begin
          state_o.open  = 1'b0;
          item_o.is_err = 1'b1;
        end else begin
          item_o.nbytes   = 3'd1;
          item_o.bytes[0] = data_byte;
          state_o.rem     = rem_dec;
          if (rem_dec == '0) begin
            item_o.add_crc = 1'b1;
            state_o.open   = 1'b0;
          end
        end
      end
      t1fb_pkg::OP_START_CTRL, t1fb_pkg::OP_START_SEQ: begin
        // control byte and sequence bit
        if (t1fb_pkg::opcode_t'(opcode) == t1fb_pkg::OP_START_CTRL) begin
          if (control_byte == t1fb_pkg::CTRL_RESYNC) begin
            state_o.seq = 1'b0;
          end
        end else begin
          ctrl        = {1'b0, state_i.seq, 6'd0};
          state_o.seq = ~state_i.seq;
        end
        state_o.open = 1'b0;
        state_o.rem  = '0;
        if (info_length > t1fb_pkg::MAX_INFO_LEN) begin
          item_o.is_err = 1'b1;
        end else begin
          item_o.restart_crc = 1'b1;
          item_o.nbytes      = 3'd4;
          item_o.bytes[0]    = node_address;
          item_o.bytes[1]    = ctrl;
          if (has_data) begin
            item_o.bytes[2] = {3'd0, info_length[12:8]};
            item_o.bytes[3] = info_length[7:0];
          end else begin
            item_o.bytes[2] = info_length[7:0];
            item_o.bytes[3] = 8'h00;
          end
          if (has_data && (info_length != '0)) begin
            state_o.open = 1'b1;
            state_o.rem  = info_length;
          end else begin
            item_o.add_crc = 1'b1;
          end
        end
      end
      default: begin
        item_valid = 1'b0;
      end
    endcase

    // result count
    if (item_o.is_err) begin
      item_o.nsteps = 3'd1;
    end else begin
      item_o.nsteps = item_o.nbytes + (item_o.add_crc ? 3'd2 : 3'd0);
    end
  end

endmodule

### rtl/t1_prime_block_frame_builder.sv
// T=1 block frame builder, top level: input register, byte sequencer with
// CRC-16 and output register. Uses t1fb_pkg and t1fb_decode.
// An accepted transaction is registered in the item register, and its first result byte then in the output register.
// Throughput: one result byte per cycle unless out_tready stalls the output; a
// transaction has payload 1, frame close 3, start 4 or 6, or error 1 results, sent
// over the single output byte lane. Unused opcode is dropped at acceptance.
// Reset (rst_n low, synchronous): no frame open, sequence bit 0, CRC 0xFFFF,
// node address 0, output empty.
module t1_prime_block_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: node_address
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: opcode[1:0], control_byte[9:2], info_length[22:10],
  //        has_data[23], data_byte[31:24]
  input  logic [31:0] in_tdata,
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // frame_byte[7:0]
  output logic        out_tlast,  // last_of_frame
  output logic        out_tuser   // error
);

  logic [7:0]             addr_r;
  t1fb_pkg::frame_state_t state_r;
  t1fb_pkg::frame_state_t state_nxt;
  t1fb_pkg::item_t        item_r;
  t1fb_pkg::item_t        item_dec;
  logic                   item_dec_valid;
  logic                   busy_r;
  logic [2:0]             idx_r;
  logic [15:0]            crc_r;
  logic [15:0]            crc_nxt;
  logic [15:0]            crc_base;
  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  logic                   out_last_r;
  logic                   out_err_r;
  logic [7:0]             byte_nxt;
  logic                   last_nxt;
  logic                   err_nxt;
  logic                   accept;
  logic                   load_ok;
  logic                   step;
  logic                   last_step;

  // decode of the incoming transaction
  t1fb_decode u_decode (
    .opcode       (in_tdata[1:0]),
    .control_byte (in_tdata[9:2]),
    .info_length  (in_tdata[22:10]),
    .has_data     (in_tdata[23]),
    .data_byte    (in_tdata[31:24]),
    .node_address (addr_r),
    .state_i      (state_r),
    .item_valid   (item_dec_valid),
    .item_o       (item_dec),
    .state_o      (state_nxt)
  );

  // handshake
  assign load_ok   = !out_valid_r || out_tready;
  assign step      = busy_r && load_ok;
  assign last_step = busy_r && (idx_r == (item_r.nsteps - 3'd1));
  assign in_tready = !busy_r || (last_step && load_ok);
  assign accept    = in_tvalid && in_tready;

  // byte selection and CRC update for the current step
  always_comb begin
    crc_base = (item_r.restart_crc && (idx_r == '0)) ? t1fb_pkg::CRC_INIT : crc_r;
    crc_nxt  = crc_r;
    byte_nxt = 8'h00;
    last_nxt = 1'b0;
    err_nxt  = 1'b0;
    if (item_r.is_err) begin
      last_nxt = 1'b1;
      err_nxt  = 1'b1;
    end else if (idx_r < item_r.nbytes) begin
      byte_nxt = item_r.bytes[idx_r[1:0]];
      crc_nxt  = t1fb_pkg::crc_step(crc_base, byte_nxt);
    end else if (idx_r == item_r.nbytes) begin
      byte_nxt = ~crc_r[15:8];
    end else begin
      byte_nxt = ~crc_r[7:0];
      last_nxt = 1'b1;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      state_r     <= '0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      crc_r       <= t1fb_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        addr_r <= cfg_wdata;
      end
      if (accept) begin
        state_r <= state_nxt;
      end
      if (step) begin
        idx_r <= last_step ? 3'd0 : idx_r + 3'd1;
        crc_r <= crc_nxt;
      end
      if (accept && item_dec_valid) begin
        busy_r <= 1'b1;
      end else if (step && last_step) begin
        busy_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_dec;
    end
    if (step) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last_nxt;
      out_err_r  <= err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

### rtl/t1fb_checker.sv
// Port checker for the T=1 block frame builder, bound to the top level.
// Depends only on the top level's ports.
module t1fb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output changed while stalled");

  // an error result always ends the frame
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("error result without tlast");

  // an error result carries a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'h00)
    else $error("error result with nonzero data");

  // output is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind t1_prime_block_frame_builder t1fb_checker u_t1fb_checker (.*);
